[hdl/lcop_pkg.sv]
`default_nettype none
package lcop_pkg;

    localparam int NumShows       = 19;
    localparam int ClassCountDef  = 5;
    localparam int ChainDepthDef  = 2;
    localparam int QueueDepth     = 2;

    localparam logic [4:0] ShowIdle      = 5'd0;
    localparam logic [4:0] ShowUnripe    = 5'd6;
    localparam logic [4:0] ShowRipe      = 5'd7;
    localparam logic [4:0] ShowAnomaly   = 5'd11;
    localparam logic [4:0] ShowAnalyzing = 5'd12;
    localparam logic [4:0] ShowBoot      = 5'd18;

    localparam logic [2:0] FuncTick    = 3'd0;
    localparam logic [2:0] FuncCue     = 3'd1;
    localparam logic [2:0] FuncBase    = 3'd2;
    localparam logic [2:0] FuncIdleCue = 3'd3;
    localparam logic [2:0] FuncResult  = 3'd4;
    localparam logic [2:0] FuncScan    = 3'd5;

    localparam logic CfgFramePeriod = 1'b0;
    localparam logic CfgResultHold  = 1'b1;

    typedef enum logic [2:0] {
        PAT_SOLID   = 3'd0,
        PAT_BREATH  = 3'd1,
        PAT_BLINK   = 3'd2,
        PAT_STROBE  = 3'd3,
        PAT_DBLINK  = 3'd4,
        PAT_FADE    = 3'd5,
        PAT_RAINBOW = 3'd6
    } t_pat;

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        t_pat        pat;
        logic [11:0] per;
        logic [10:0] dur;
        logic        hold;
    } t_show;

    typedef struct packed {
        logic [2:0] func;
        logic [4:0] show_id;
        logic [2:0] class_index;
        logic       class_known;
        logic       anomaly;
        logic       scan_on;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    // one frame to render: show index and time, relative to the cue start while a cue plays
    typedef struct packed {
        logic [4:0]  id;
        logic [31:0] t;
    } t_job;

    function automatic t_show show_rom(input logic [4:0] id);
        t_show s;
        unique case (id)
            5'd0:  s = '{8'd40,  8'd120, 8'd255, PAT_BREATH,  12'd3333, 11'd0,    1'b0};
            5'd1:  s = '{8'd255, 8'd255, 8'd255, PAT_BLINK,   12'd416,  11'd900,  1'b0};
            5'd2:  s = '{8'd0,   8'd255, 8'd255, PAT_BLINK,   12'd500,  11'd0,    1'b0};
            5'd3:  s = '{8'd160, 8'd82,  8'd45,  PAT_BREATH,  12'd1000, 11'd0,    1'b0};
            5'd4:  s = '{8'd255, 8'd255, 8'd255, PAT_SOLID,   12'd0,    11'd400,  1'b0};
            5'd5:  s = '{8'd160, 8'd82,  8'd45,  PAT_SOLID,   12'd0,    11'd700,  1'b0};
            5'd6:  s = '{8'd0,   8'd255, 8'd60,  PAT_SOLID,   12'd0,    11'd0,    1'b1};
            5'd7:  s = '{8'd200, 8'd255, 8'd0,   PAT_SOLID,   12'd0,    11'd0,    1'b1};
            5'd8:  s = '{8'd255, 8'd140, 8'd0,   PAT_SOLID,   12'd0,    11'd0,    1'b1};
            5'd9:  s = '{8'd255, 8'd30,  8'd30,  PAT_BLINK,   12'd500,  11'd0,    1'b1};
            5'd10: s = '{8'd255, 8'd0,   8'd255, PAT_BLINK,   12'd250,  11'd0,    1'b1};
            5'd11: s = '{8'd255, 8'd40,  8'd40,  PAT_STROBE,  12'd62,   11'd0,    1'b1};
            5'd12: s = '{8'd255, 8'd190, 8'd0,   PAT_STROBE,  12'd62,   11'd500,  1'b0};
            5'd13: s = '{8'd255, 8'd110, 8'd20,  PAT_DBLINK,  12'd250,  11'd1500, 1'b0};
            5'd14: s = '{8'd255, 8'd40,  8'd40,  PAT_BLINK,   12'd166,  11'd1500, 1'b0};
            5'd15: s = '{8'd80,  8'd140, 8'd255, PAT_FADE,    12'd0,    11'd800,  1'b0};
            5'd16: s = '{8'd180, 8'd80,  8'd255, PAT_BLINK,   12'd125,  11'd1500, 1'b0};
            5'd17: s = '{8'd255, 8'd60,  8'd60,  PAT_DBLINK,  12'd250,  11'd1200, 1'b0};
            5'd18: s = '{8'd0,   8'd0,   8'd0,   PAT_RAINBOW, 12'd0,    11'd1200, 1'b0};
            default: s = '{8'd0, 8'd0,   8'd0,   PAT_SOLID,   12'd0,    11'd0,    1'b0};
        endcase
        return s;
    endfunction

    function automatic logic [15:0] show_duration(input logic [4:0] id,
                                                  input logic [15:0] hold_ms);
        t_show s;
        s = show_rom(id);
        return s.hold ? hold_ms : {5'd0, s.dur};
    endfunction

    function automatic logic [7:0] quarter_sine(input logic [6:0] k);
        logic [7:0] v;
        unique case (k)
            7'd0: v = 8'd0;     7'd1: v = 8'd6;     7'd2: v = 8'd13;    7'd3: v = 8'd19;
            7'd4: v = 8'd25;    7'd5: v = 8'd31;    7'd6: v = 8'd37;    7'd7: v = 8'd44;
            7'd8: v = 8'd50;    7'd9: v = 8'd56;    7'd10: v = 8'd62;   7'd11: v = 8'd68;
            7'd12: v = 8'd74;   7'd13: v = 8'd80;   7'd14: v = 8'd86;   7'd15: v = 8'd92;
            7'd16: v = 8'd98;   7'd17: v = 8'd103;  7'd18: v = 8'd109;  7'd19: v = 8'd115;
            7'd20: v = 8'd120;  7'd21: v = 8'd126;  7'd22: v = 8'd131;  7'd23: v = 8'd136;
            7'd24: v = 8'd142;  7'd25: v = 8'd147;  7'd26: v = 8'd152;  7'd27: v = 8'd157;
            7'd28: v = 8'd162;  7'd29: v = 8'd167;  7'd30: v = 8'd171;  7'd31: v = 8'd176;
            7'd32: v = 8'd180;  7'd33: v = 8'd185;  7'd34: v = 8'd189;  7'd35: v = 8'd193;
            7'd36: v = 8'd197;  7'd37: v = 8'd201;  7'd38: v = 8'd205;  7'd39: v = 8'd208;
            7'd40: v = 8'd212;  7'd41: v = 8'd215;  7'd42: v = 8'd219;  7'd43: v = 8'd222;
            7'd44: v = 8'd225;  7'd45: v = 8'd228;  7'd46: v = 8'd231;  7'd47: v = 8'd233;
            7'd48: v = 8'd236;  7'd49: v = 8'd238;  7'd50: v = 8'd240;  7'd51: v = 8'd242;
            7'd52: v = 8'd244;  7'd53: v = 8'd246;  7'd54: v = 8'd247;  7'd55: v = 8'd249;
            7'd56: v = 8'd250;  7'd57: v = 8'd251;  7'd58: v = 8'd252;  7'd59: v = 8'd253;
            7'd60: v = 8'd254;  7'd61: v = 8'd254;  7'd62: v = 8'd255;  7'd63: v = 8'd255;
            7'd64: v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] half_sine(input logic [6:0] h);
        logic [7:0] m;
        m = 8'd128 - {1'b0, h};
        return (h <= 7'd64) ? quarter_sine(h) : quarter_sine(m[6:0]);
    endfunction

    // x / 255 for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage
`default_nettype wire

[hdl/lcop_fifo.sv]
`default_nettype none
module lcop_fifo #(
    parameter type T = logic,
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire T     i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output T          o_data,
    output logic      o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end
endmodule
`default_nettype wire

[hdl/lcop_div.sv]
`default_nettype none
module lcop_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [15:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quo,
    output logic [15:0]      o_rem
);
    logic        r_busy, r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [15:0] r_rem, r_div;
    logic [16:0] sh, diff;
    logic        ge;

    // restoring divide, one quotient bit per cycle
    assign sh   = {r_rem, r_quo[31]};
    assign ge   = sh >= {1'b0, r_div};
    assign diff = ge ? sh - {1'b0, r_div} : sh;

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], ge};
            r_rem <= diff[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[hdl/lcop_front.sv]
`default_nettype none
module lcop_front #(
    parameter int CLASS_COUNT = lcop_pkg::ClassCountDef,
    parameter int CHAIN_DEPTH = lcop_pkg::ChainDepthDef
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_accept,
    input  wire lcop_pkg::t_in_item i_item,
    input  wire logic [9:0]         i_frame_period,
    input  wire logic [15:0]        i_hold_ms,
    output logic                    o_job_push,
    output lcop_pkg::t_job          o_job
);
    localparam int CQW = $clog2(CHAIN_DEPTH + 1);

    logic [31:0]    r_time, r_last, r_cue_start, r_cue_end;
    logic [4:0]     r_base, r_cue_show;
    logic           r_cue_active, r_scan;
    logic [4:0]     r_chain [CHAIN_DEPTH];
    logic [CQW-1:0] r_chain_cnt;

    logic [31:0] tick_time, eff_start;
    logic        is_tick, frame, expire, advance, eff_active, id_ok;
    logic [4:0]  eff_show, res_show;

    assign is_tick   = i_accept && (i_item.func == lcop_pkg::FuncTick);
    assign tick_time = r_time + 32'd1;
    assign frame     = (tick_time - r_last) >= {22'd0, i_frame_period};
    assign expire    = r_cue_active && (tick_time >= r_cue_end);
    assign advance   = expire && (r_chain_cnt != '0);
    assign id_ok     = i_item.show_id < 5'(lcop_pkg::NumShows);

    always_comb begin
        eff_active = r_cue_active && !(expire && !advance);
        eff_show   = advance ? r_chain[0] : r_cue_show;
        eff_start  = advance ? tick_time : r_cue_start;
    end

    always_comb begin
        res_show = lcop_pkg::ShowRipe;
        if (i_item.anomaly) begin
            res_show = lcop_pkg::ShowAnomaly;
        end else if (i_item.class_known && ({29'd0, i_item.class_index} < CLASS_COUNT)) begin
            res_show = lcop_pkg::ShowUnripe + {2'd0, i_item.class_index};
        end
    end

    assign o_job_push = is_tick && frame && !r_scan;

    always_comb begin
        o_job.id = eff_active ? eff_show : r_base;
        o_job.t  = eff_active ? tick_time - eff_start : tick_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_last       <= '0;
            r_base       <= lcop_pkg::ShowIdle;
            r_cue_show   <= lcop_pkg::ShowBoot;
            r_cue_active <= 1'b1;
            r_cue_start  <= '0;
            r_cue_end    <= 32'd1200;
            r_chain_cnt  <= '0;
            r_scan       <= 1'b0;
            for (int i = 0; i < CHAIN_DEPTH; i++) begin
                r_chain[i] <= '0;
            end
        end else if (i_accept) begin
            unique case (i_item.func)
                lcop_pkg::FuncTick: begin
                    r_time <= tick_time;
                    if (frame) begin
                        r_last <= tick_time;
                        if (!r_scan && expire) begin
                            if (advance) begin
                                for (int i = 0; i + 1 < CHAIN_DEPTH; i++) begin
                                    r_chain[i] <= r_chain[i+1];
                                end
                                r_chain_cnt <= r_chain_cnt - 1'b1;
                                r_cue_show  <= r_chain[0];
                                r_cue_start <= tick_time;
                                r_cue_end   <= tick_time +
                                    {16'd0, lcop_pkg::show_duration(r_chain[0], i_hold_ms)};
                            end else begin
                                r_cue_active <= 1'b0;
                            end
                        end
                    end
                end
                lcop_pkg::FuncCue: begin
                    if (id_ok) begin
                        r_cue_show   <= i_item.show_id;
                        r_cue_active <= 1'b1;
                        r_cue_start  <= r_time;
                        r_cue_end    <= r_time +
                            {16'd0, lcop_pkg::show_duration(i_item.show_id, i_hold_ms)};
                    end
                end
                lcop_pkg::FuncBase: begin
                    if (id_ok) begin
                        r_base       <= i_item.show_id;
                        r_cue_active <= 1'b0;
                        r_chain_cnt  <= '0;
                    end
                end
                lcop_pkg::FuncIdleCue: begin
                    if (id_ok) begin
                        r_base       <= lcop_pkg::ShowIdle;
                        r_chain_cnt  <= '0;
                        r_cue_show   <= i_item.show_id;
                        r_cue_active <= 1'b1;
                        r_cue_start  <= r_time;
                        r_cue_end    <= r_time +
                            {16'd0, lcop_pkg::show_duration(i_item.show_id, i_hold_ms)};
                    end
                end
                lcop_pkg::FuncResult: begin
                    r_base       <= lcop_pkg::ShowIdle;
                    r_cue_show   <= lcop_pkg::ShowAnalyzing;
                    r_cue_active <= 1'b1;
                    r_cue_start  <= r_time;
                    r_cue_end    <= r_time +
                        {16'd0, lcop_pkg::show_duration(lcop_pkg::ShowAnalyzing, i_hold_ms)};
                    r_chain[0]   <= res_show;
                    r_chain_cnt  <= CQW'(1);
                end
                lcop_pkg::FuncScan: begin
                    r_scan <= i_item.scan_on;
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/lcop_render.sv]
`default_nettype none
module lcop_render (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_job_empty,
    input  wire lcop_pkg::t_job      i_job,
    output logic                     o_job_pop,
    input  wire logic [15:0]         i_hold_ms,
    input  wire logic                i_out_full,
    output logic                     o_out_push,
    output lcop_pkg::t_out_item      o_out
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_DIV1  = 7'b0000100,
        S_DIV2  = 7'b0001000,
        S_AMP   = 7'b0010000,
        S_MUL   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state          r_state;
    logic [4:0]      r_id;
    logic [31:0]     r_t;
    logic [7:0]      r_fac;
    lcop_pkg::t_out_item r_col;

    lcop_pkg::t_show show;
    logic [15:0] per_eff, dur_eff, divisor, dur_raw;
    logic [31:0] dividend, quo;
    logic [15:0] rem;
    logic        div_start, div_done, db_on;
    logic [7:0]  hs, hue, f, qv, tv;
    logic [10:0] h6;
    logic [8:0]  v;

    assign show    = lcop_pkg::show_rom(r_id);
    assign per_eff = (show.per == '0) ? 16'd1 : {4'd0, show.per};
    assign dur_raw = lcop_pkg::show_duration(r_id, i_hold_ms);
    assign dur_eff = (dur_raw == '0) ? 16'd1 : dur_raw;

    always_comb begin
        unique case (show.pat)
            lcop_pkg::PAT_DBLINK: divisor = per_eff * 16'd6;
            lcop_pkg::PAT_FADE:   divisor = dur_eff;
            default:              divisor = per_eff;
        endcase
    end

    // first pass divides the time, second scales the remainder to a phase
    always_comb begin
        if (r_state == S_SETUP) begin
            dividend = r_t;
        end else if (show.pat == lcop_pkg::PAT_BREATH) begin
            dividend = {8'd0, rem, 8'd0};
        end else begin
            dividend = {9'd0, rem, 7'd0};
        end
    end

    assign div_start = ((r_state == S_SETUP) &&
                        (show.pat == lcop_pkg::PAT_BREATH || show.pat == lcop_pkg::PAT_BLINK ||
                         show.pat == lcop_pkg::PAT_STROBE || show.pat == lcop_pkg::PAT_DBLINK ||
                         show.pat == lcop_pkg::PAT_FADE)) ||
                       ((r_state == S_DIV1) && div_done &&
                        (show.pat == lcop_pkg::PAT_BREATH || show.pat == lcop_pkg::PAT_FADE));

    lcop_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_done     (div_done),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    assign db_on = (rem < per_eff) || ((rem >= (per_eff << 1)) && (rem < per_eff * 16'd3));
    assign hs    = lcop_pkg::half_sine(quo[6:0]);
    assign v     = quo[7] ? (9'd255 - {1'b0, hs}) >> 1 : (9'd255 + {1'b0, hs}) >> 1;

    assign hue = r_t[10:3];
    assign h6  = {3'd0, hue} * 11'd6;
    assign f   = h6[7:0];
    assign qv  = lcop_pkg::div255(16'd200 * {8'd0, 8'd255 - f});
    assign tv  = lcop_pkg::div255(16'd200 * {8'd0, f});

    assign o_job_pop  = (r_state == S_IDLE) && !i_job_empty;
    assign o_out_push = (r_state == S_OUT) && !i_out_full;
    assign o_out      = r_col;

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_id <= i_job.id;
            r_t  <= i_job.t;
        end
        unique case (r_state)
            S_SETUP: begin
                if (show.pat == lcop_pkg::PAT_RAINBOW) begin
                    unique case (h6[10:8])
                        3'd0:    r_col <= '{8'd200, tv, 8'd0};
                        3'd1:    r_col <= '{qv, 8'd200, 8'd0};
                        3'd2:    r_col <= '{8'd0, 8'd200, tv};
                        3'd3:    r_col <= '{8'd0, qv, 8'd200};
                        3'd4:    r_col <= '{tv, 8'd0, 8'd200};
                        default: r_col <= '{8'd200, 8'd0, qv};
                    endcase
                end else begin
                    r_col <= '{show.r, show.g, show.b};
                end
            end
            S_DIV1: begin
                if (div_done) begin
                    if (show.pat == lcop_pkg::PAT_BLINK && quo[0]) begin
                        r_col <= '{8'd0, 8'd0, 8'd0};
                    end else if (show.pat == lcop_pkg::PAT_STROBE && quo[0]) begin
                        r_col <= '{8'd255, 8'd255, 8'd255};
                    end else if (show.pat == lcop_pkg::PAT_DBLINK && !db_on) begin
                        r_col <= '{show.r >> 2, show.g >> 2, show.b >> 2};
                    end else begin
                        r_col <= '{show.r, show.g, show.b};
                    end
                end
            end
            S_DIV2: begin
                if (div_done) begin
                    r_fac <= (show.pat == lcop_pkg::PAT_BREATH) ? v[7:0] : hs;
                end
            end
            S_AMP: begin
                r_fac <= 8'd51 + lcop_pkg::div255({8'd0, r_fac} * 16'd204);
            end
            S_MUL: begin
                r_col <= '{lcop_pkg::div255({8'd0, show.r} * {8'd0, r_fac}),
                           lcop_pkg::div255({8'd0, show.g} * {8'd0, r_fac}),
                           lcop_pkg::div255({8'd0, show.b} * {8'd0, r_fac})};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_job_empty) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= div_start ? S_DIV1 : S_OUT;
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_state <= div_start ? S_DIV2 : S_OUT;
                    end
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_state <= (show.pat == lcop_pkg::PAT_BREATH) ? S_AMP : S_MUL;
                    end
                end
                S_AMP: r_state <= S_MUL;
                S_MUL: r_state <= S_OUT;
                S_OUT: begin
                    if (!i_out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[hdl/led_cue_overlay_player.sv]
// RGB status light cue player. Items go in through a queue-style push/full port and
// rendered colours come out through empty/pop. The front end takes one item per clock
// while full is low, updates the cue/chain/time state at once and, on a frame tick with
// scan mode off, posts a render request into a two-deep queue; full rises only while
// that queue is full. The renderer works one frame at a time: solid and rainbow need no
// divide, blink, strobe and double blink take one pass of the shared bit-serial 32-bit
// divider, and fade and breath take two. Results wait in a two-deep output queue.
// Configuration writes are always ready and should be issued while idle.
`default_nettype none
module led_cue_overlay_player #(
    parameter int CLASS_COUNT = lcop_pkg::ClassCountDef,
    parameter int CHAIN_DEPTH = lcop_pkg::ChainDepthDef
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    output logic                     o_full,
    input  wire lcop_pkg::t_in_item  i_in,
    output logic                     o_empty,
    input  wire logic                i_pop,
    output lcop_pkg::t_out_item      o_out,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    logic [9:0]  r_frame_period;
    logic [15:0] r_hold_ms;

    logic           accept, job_push, job_full, job_empty, job_pop;
    lcop_pkg::t_job job_in, job_out;
    logic           out_push, out_full;
    lcop_pkg::t_out_item out_item;

    assign o_cfg_ready = 1'b1;
    assign o_full      = job_full;
    assign accept      = i_push && !job_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_period <= 10'd20;
            r_hold_ms      <= 16'd3000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lcop_pkg::CfgFramePeriod: r_frame_period <= i_cfg_data[9:0];
                lcop_pkg::CfgResultHold:  r_hold_ms      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    lcop_front #(
        .CLASS_COUNT (CLASS_COUNT),
        .CHAIN_DEPTH (CHAIN_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_item         (i_in),
        .i_frame_period (r_frame_period),
        .i_hold_ms      (r_hold_ms),
        .o_job_push     (job_push),
        .o_job          (job_in)
    );

    lcop_fifo #(
        .T     (lcop_pkg::t_job),
        .DEPTH (lcop_pkg::QueueDepth)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    lcop_render u_render (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_hold_ms   (r_hold_ms),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out       (out_item)
    );

    lcop_fifo #(
        .T     (lcop_pkg::t_out_item),
        .DEPTH (lcop_pkg::QueueDepth)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_item),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_out),
        .o_empty (o_empty)
    );
endmodule
`default_nettype wire
